/* hw/rtl/linked_list_queue_free_pool_defines.svh */
// Assertion macros shared by the linked-list queue RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef LINKED_LIST_QUEUE_FREE_POOL_DEFINES_SVH
`define LINKED_LIST_QUEUE_FREE_POOL_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LLQFP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define LLQFP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Delayed implication, disabled during reset.
`define LLQFP_ASSERT_TWO(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) else $error(msg);

`endif

/* hw/rtl/llqfp_pkg.sv */
// Shared constants, operation codes and controller/datapath structs for the
// linked-list queue with free pool. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package llqfp_pkg;

   localparam int DEF_POOL_DEPTH  = 1024;
   localparam int RESET_POOL_SIZE = 1024;
   localparam int CSR_W           = 11;
   localparam int DATA_W          = 32;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_READ  = 1'b1;

   typedef struct packed {
      logic capture;
      logic enq;
      logic deq;
      logic finish;
   } ctl_cmd_type;

   typedef struct packed {
      logic queue_empty;
      logic pool_exhausted;
   } dp_status_type;

endpackage

`default_nettype wire

/* hw/rtl/llqfp_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module llqfp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

/* hw/rtl/llqfp_ctrl.sv */
// Controller state machine for the linked-list queue: handshakes and commands.
// Depends on llqfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module llqfp_ctrl
   import llqfp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output      logic          req_ready,
   input  wire logic          req_func,
   output      logic          rsp_valid,
   input  wire logic          rsp_ready,
   input  wire dp_status_type status,
   output      ctl_cmd_type   cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      op_ff, op_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.capture = accept;
      cmd.finish  = (state_ff == ST_EXEC);
      cmd.enq     = (state_ff == ST_EXEC) && (op_ff == FUNC_WRITE) && !status.pool_exhausted;
      cmd.deq     = (state_ff == ST_EXEC) && (op_ff == FUNC_READ) && !status.queue_empty;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
               op_in    = req_func;
            end
         end
         ST_EXEC: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= FUNC_WRITE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/llqfp_dp.sv */
// Datapath for the linked-list queue: node and free-stack memories, queue
// pointers and the result register. Depends on llqfp_pkg and llqfp_ram.
`timescale 1ns / 1ps
`default_nettype none

module llqfp_dp
   import llqfp_pkg::*;
#(
   parameter int POOL_DEPTH = DEF_POOL_DEPTH
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ctl_cmd_type         cmd,
   output      dp_status_type       status,
   input  wire logic signed [DATA_W-1:0] req_write_value,
   input  wire logic                csr_wr_en,
   input  wire logic [CSR_W-1:0]    csr_wr_data,
   output      logic                rsp_ok,
   output      logic signed [DATA_W-1:0] rsp_read_value
);

   localparam int IDX_W      = $clog2(POOL_DEPTH);
   localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
   localparam int RESET_SIZE = (RESET_POOL_SIZE > POOL_DEPTH) ? POOL_DEPTH : RESET_POOL_SIZE;

   logic [CNT_W-1:0]  pool_size_ff, free_count_ff, low_mark_ff;
   logic [CNT_W-1:0]  pool_size_in, free_count_in, low_mark_in;
   logic [IDX_W-1:0]  head_ff, tail_ff, head_in, tail_in;
   logic              empty_ff, empty_in;
   logic [DATA_W-1:0] wval_ff;
   logic              rsp_ok_ff;
   logic [DATA_W-1:0] rsp_read_value_ff;

   logic [CNT_W-1:0]  csr_size;
   logic [31:0]       csr_wide;
   logic [DATA_W-1:0] value_rdata;
   logic [IDX_W-1:0]  link_rdata, stack_rdata, pop_idx;
   logic [IDX_W-1:0]  stack_rd_addr;
   logic              last_node;

   // Clamp the written size into 1 .. POOL_DEPTH.
   always_comb begin
      csr_wide = 32'(csr_wr_data);
      if (csr_wide == 32'd0) begin
         csr_size = CNT_W'(1);
      end else if (csr_wide > 32'(POOL_DEPTH)) begin
         csr_size = CNT_W'(POOL_DEPTH);
      end else begin
         csr_size = CNT_W'(csr_wide);
      end
   end

   // Stack slots below the low-water mark were never written since the last
   // reinitialisation; their index pool_size-1-slot is computed, not read.
   assign stack_rd_addr = IDX_W'(free_count_ff - CNT_W'(1));
   assign pop_idx       = (free_count_ff == low_mark_ff)
                          ? IDX_W'(pool_size_ff - free_count_ff) : stack_rdata;
   assign last_node     = (head_ff == tail_ff);

   assign status.queue_empty    = empty_ff;
   assign status.pool_exhausted = (free_count_ff == '0);

   llqfp_ram #(.WIDTH(DATA_W), .DEPTH(POOL_DEPTH)) u_value_ram (
      .clock   (clock),
      .wr_en   (cmd.enq),
      .wr_addr (pop_idx),
      .wr_data (wval_ff),
      .rd_addr (head_ff),
      .rd_data (value_rdata)
   );

   llqfp_ram #(.WIDTH(IDX_W), .DEPTH(POOL_DEPTH)) u_link_ram (
      .clock   (clock),
      .wr_en   (cmd.enq && !empty_ff),
      .wr_addr (tail_ff),
      .wr_data (pop_idx),
      .rd_addr (head_ff),
      .rd_data (link_rdata)
   );

   llqfp_ram #(.WIDTH(IDX_W), .DEPTH(POOL_DEPTH)) u_stack_ram (
      .clock   (clock),
      .wr_en   (cmd.deq),
      .wr_addr (IDX_W'(free_count_ff)),
      .wr_data (head_ff),
      .rd_addr (stack_rd_addr),
      .rd_data (stack_rdata)
   );

   always_comb begin
      pool_size_in  = pool_size_ff;
      free_count_in = free_count_ff;
      low_mark_in   = low_mark_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      empty_in      = empty_ff;
      if (csr_wr_en) begin
         pool_size_in  = csr_size;
         free_count_in = csr_size;
         low_mark_in   = csr_size;
         head_in       = '0;
         tail_in       = '0;
         empty_in      = 1'b1;
      end else if (cmd.enq) begin
         free_count_in = free_count_ff - CNT_W'(1);
         if (free_count_ff == low_mark_ff) begin
            low_mark_in = free_count_ff - CNT_W'(1);
         end
         if (empty_ff) begin
            head_in = pop_idx;
         end
         tail_in  = pop_idx;
         empty_in = 1'b0;
      end else if (cmd.deq) begin
         free_count_in = free_count_ff + CNT_W'(1);
         if (last_node) begin
            empty_in = 1'b1;
         end else begin
            head_in = link_rdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_size_ff  <= CNT_W'(RESET_SIZE);
         free_count_ff <= CNT_W'(RESET_SIZE);
         low_mark_ff   <= CNT_W'(RESET_SIZE);
         head_ff       <= '0;
         tail_ff       <= '0;
         empty_ff      <= 1'b1;
      end else begin
         pool_size_ff  <= pool_size_in;
         free_count_ff <= free_count_in;
         low_mark_ff   <= low_mark_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         empty_ff      <= empty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         wval_ff <= req_write_value;
      end
      if (cmd.finish) begin
         rsp_ok_ff         <= cmd.enq || cmd.deq;
         rsp_read_value_ff <= cmd.deq ? value_rdata : '0;
      end
   end

   assign rsp_ok         = rsp_ok_ff;
   assign rsp_read_value = rsp_read_value_ff;

endmodule

`default_nettype wire

/* hw/rtl/linked_list_queue_free_pool.sv */
// Top level of the linked-list queue with free node pool.
// Depends on llqfp_pkg, llqfp_ctrl, llqfp_dp and the assertion macro header.
//
// Usage:
// The request channel (req_*) carries one transaction per operation: req_func
// selects enqueue (write) or dequeue (read), req_write_value is the value to
// enqueue. Every request yields exactly one transaction on the response
// channel (rsp_*): rsp_ok reports success (failure means no node was free or
// the queue was empty) and rsp_read_value carries the dequeued value, or zero.
// rsp_valid rises from a register set as the controller leaves its execute
// state. The block works on one transaction at a time and accepts no new
// request before it is through with the last: each passes through the idle
// and execute states, with the registered read of the node and free-stack
// memories and the write-back. A new request is accepted while a response
// still waits, provided the response is taken in that same cycle.
// If the receiver stalls, the response is held in the output register and no
// further request is accepted until it is taken.
// Reset empties the queue and sets the pool size to 1024 (or POOL_DEPTH if
// smaller), with every node free; no memory clearing pass is needed.
// A write on csr_wr_en sets the pool size (clamped to 1..POOL_DEPTH) and
// reinitialises the queue in the same way; it should only be issued when idle.
`timescale 1ns / 1ps
`default_nettype none
`include "linked_list_queue_free_pool_defines.svh"

module linked_list_queue_free_pool
   import llqfp_pkg::*;
#(
   parameter int POOL_DEPTH = DEF_POOL_DEPTH
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output      logic                     req_ready,
   input  wire logic                     req_func,
   input  wire logic signed [DATA_W-1:0] req_write_value,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   output      logic                     rsp_ok,
   output      logic signed [DATA_W-1:0] rsp_read_value,
   input  wire logic                     csr_wr_en,
   input  wire logic [CSR_W-1:0]         csr_wr_data
);

   ctl_cmd_type   cmd;
   dp_status_type status;

   // Controller: handshakes, operation latch and per-cycle commands.
   llqfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: memories, queue pointers, free-stack count and result register.
   llqfp_dp #(.POOL_DEPTH(POOL_DEPTH)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_write_value (req_write_value),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_ok          (rsp_ok),
      .rsp_read_value  (rsp_read_value)
   );

   // Only one transaction is in flight: no acceptance in the following cycle.
   `LLQFP_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready, "request accepted while another is in flight")
   // Every accepted request produces a response after the execute state.
   `LLQFP_ASSERT_TWO(a_rsp_latency, clock, reset, req_valid && req_ready, rsp_valid, "response missing two cycles after acceptance")
   // A failed operation never returns data.
   `LLQFP_ASSERT_NOW(a_fail_zero, clock, reset, rsp_valid && !rsp_ok, rsp_read_value == '0, "failed operation returned non-zero data")
   // Enqueue and dequeue commands are never issued together.
   `LLQFP_ASSERT_NOW(a_cmd_excl, clock, reset, cmd.enq, !cmd.deq, "enqueue and dequeue issued together")

endmodule

`default_nettype wire
